FILE: rtl/text_terminal_cursor_scroll_assert.svh
// Assertion macros for the text terminal block.
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_ASSERT_SVH
`ifndef SYNTHESIS
`define TTCS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ttcs assertion failed");
`define TTCS_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("ttcs assertion failed");
`else
`define TTCS_ASSERT(lbl, prop)
`define TTCS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/ttcs_pkg.sv
// Shared constants, codes and helpers for the text terminal block.
package ttcs_pkg;
	localparam int SCREEN_WIDTH  = 80;
	localparam int SCREEN_HEIGHT = 25;
	localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W        = $clog2(CELL_COUNT);
	localparam int CNT_W         = $clog2(CELL_COUNT + 1);
	localparam int COL_W         = 7;
	localparam int ROW_W         = 5;
	localparam int CHAR_W        = 8;
	localparam int IDX_W         = 11;
	localparam int CELL_W        = 16;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
	localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'd224;

	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_SET   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		cell_addr = ADDR_W'(row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col);
	endfunction
endpackage

FILE: rtl/ttcs_item_if.sv
// Input item channel of the text terminal.
interface ttcs_item_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       mode;
	logic [ttcs_pkg::CHAR_W-1:0]      char_code;
	logic [ttcs_pkg::COL_W-1:0]       new_col;
	logic [ttcs_pkg::ROW_W-1:0]       new_row;
	logic [ttcs_pkg::IDX_W-1:0]       cell_index;

	modport source (output valid, mode, char_code, new_col, new_row, cell_index, input ready);
	modport sink (input valid, mode, char_code, new_col, new_row, cell_index, output ready);
endinterface

FILE: rtl/ttcs_result_if.sv
// Result channel of the text terminal.
interface ttcs_result_if;
	logic                          valid;
	logic                          ready;
	logic [ttcs_pkg::COL_W-1:0]    cursor_col;
	logic [ttcs_pkg::ROW_W-1:0]    cursor_row;
	logic [ttcs_pkg::CELL_W-1:0]   cell_value;

	modport source (output valid, cursor_col, cursor_row, cell_value, input ready);
	modport sink (input valid, cursor_col, cursor_row, cell_value, output ready);
endinterface

FILE: rtl/ttcs_cfg_if.sv
// Configuration write channel of the text terminal.
interface ttcs_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ttcs_pkg::CHAR_W-1:0]   text_color;

	modport source (output valid, text_color, input ready);
	modport sink (input valid, text_color, output ready);
endinterface

FILE: rtl/ttcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ttcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/text_terminal_cursor_scroll.sv
// Text terminal: screen store in RAM, cursor, lazy wrap, scroll, clear and cell read.
// Put (no scroll), set cursor and read: ST_EXEC, then ST_FIN registers the result when the
// output is free; the next item is accepted only as that result is loaded.
// Scroll walks the RAM port in ST_SCROLL (copy rows up), ST_FILL (blank last row) and ST_POST.
// Clear screen: ST_FILL blanks every cell; item.ready is low meanwhile. cfg.ready is always high.
// Reset: cursor 0,0, attribute 224; then a clearing pass over every cell with item.ready low.
`include "text_terminal_cursor_scroll_assert.svh"
module text_terminal_cursor_scroll (
	input  logic            clk,
	input  logic            arst_n,
	ttcs_item_if.sink       item,
	ttcs_result_if.source   result,
	ttcs_cfg_if.sink        cfg
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_SCROLL = 3'd2;
	localparam logic [2:0] ST_FILL   = 3'd3;
	localparam logic [2:0] ST_POST   = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	localparam int AW = ttcs_pkg::ADDR_W;
	localparam int CW = ttcs_pkg::CNT_W;
	localparam logic [CW-1:0] COPY_END   = CW'(ttcs_pkg::CELL_COUNT - ttcs_pkg::SCREEN_WIDTH);
	localparam logic [CW-1:0] FILL_END   = CW'(ttcs_pkg::CELL_COUNT);
	localparam logic [CW-1:0] BOTTOM_ROW = CW'((ttcs_pkg::SCREEN_HEIGHT - 1) *
		ttcs_pkg::SCREEN_WIDTH);
	localparam logic [ttcs_pkg::COL_W-1:0] COL_MAX = ttcs_pkg::COL_W'(ttcs_pkg::SCREEN_WIDTH);
	localparam logic [ttcs_pkg::ROW_W-1:0] ROW_MAX = ttcs_pkg::ROW_W'(ttcs_pkg::SCREEN_HEIGHT - 1);

	logic [2:0]                        st_q;
	logic                              init_q;
	logic [ttcs_pkg::CHAR_W-1:0]       color_q;
	logic [ttcs_pkg::COL_W-1:0]        col_q;
	logic [ttcs_pkg::ROW_W-1:0]        row_q;
	logic [1:0]                        mode_q;
	logic [ttcs_pkg::CHAR_W-1:0]       char_q;
	logic [ttcs_pkg::COL_W-1:0]        ncol_q;
	logic [ttcs_pkg::ROW_W-1:0]        nrow_q;
	logic [ttcs_pkg::IDX_W-1:0]        cidx_q;
	logic                              rd_ok_q;
	logic [CW-1:0]                     cnt_q;
	logic                              wv_s1;
	logic [AW-1:0]                     wa_s1;
	logic                              out_valid_q;
	logic [ttcs_pkg::COL_W-1:0]        out_col_q;
	logic [ttcs_pkg::ROW_W-1:0]        out_row_q;
	logic [ttcs_pkg::CELL_W-1:0]       out_cell_q;

	logic                              load_out;
	logic                              accept;
	logic                              nl;
	logic                              wrap;
	logic                              last_row;
	logic                              need_scroll;
	logic                              rd_in_range;
	logic [ttcs_pkg::COL_W-1:0]        p_col;
	logic [ttcs_pkg::ROW_W-1:0]        p_row;
	logic [ttcs_pkg::CHAR_W-1:0]       fill_attr;
	logic                              ram_we;
	logic [AW-1:0]                     ram_waddr;
	logic [ttcs_pkg::CELL_W-1:0]       ram_wdata;
	logic                              ram_re;
	logic [AW-1:0]                     ram_raddr;
	logic [ttcs_pkg::CELL_W-1:0]       ram_rdata;

	assign load_out    = (st_q == ST_FIN) && (!out_valid_q || result.ready);
	assign item.ready  = (st_q == ST_IDLE) || load_out;
	assign accept      = item.valid && item.ready;
	assign cfg.ready   = 1'b1;

	assign nl          = (char_q == ttcs_pkg::NEWLINE_CODE);
	assign wrap        = (col_q >= COL_MAX) || nl;
	assign last_row    = (row_q >= ROW_MAX);
	assign need_scroll = wrap && last_row;
	assign rd_in_range = (cidx_q < ttcs_pkg::IDX_W'(ttcs_pkg::CELL_COUNT));
	assign fill_attr   = init_q ? ttcs_pkg::RESET_ATTR : color_q;

	always_comb begin
		if (st_q == ST_POST || !wrap) begin
			p_col = col_q;
			p_row = row_q;
		end else begin
			p_col = '0;
			p_row = row_q + ttcs_pkg::ROW_W'(1);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ttcs_pkg::cell_addr(p_row, p_col);
		ram_wdata = {color_q, char_q};
		ram_re    = 1'b0;
		ram_raddr = cidx_q[AW-1:0];
		unique case (st_q)
			ST_EXEC: begin
				ram_we = (mode_q == ttcs_pkg::MODE_PUT) && !need_scroll && !nl;
				ram_re = (mode_q == ttcs_pkg::MODE_READ) && rd_in_range;
			end
			ST_SCROLL: begin
				ram_we    = wv_s1;
				ram_waddr = wa_s1;
				ram_wdata = ram_rdata;
				ram_re    = (cnt_q < COPY_END);
				ram_raddr = AW'(cnt_q + CW'(ttcs_pkg::SCREEN_WIDTH));
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = {fill_attr, ttcs_pkg::BLANK_CODE};
			end
			ST_POST: begin
				ram_we = !nl;
			end
			default: begin
			end
		endcase
	end

	ttcs_ram #(
		.WIDTH(ttcs_pkg::CELL_W),
		.DEPTH(ttcs_pkg::CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_FILL;
			init_q      <= 1'b1;
			color_q     <= ttcs_pkg::RESET_ATTR;
			col_q       <= '0;
			row_q       <= '0;
			cnt_q       <= '0;
			wv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				color_q <= cfg.text_color;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q) inside
				ST_IDLE, ST_FIN: begin
					if (accept) begin
						st_q <= ST_EXEC;
					end else if (load_out) begin
						st_q <= ST_IDLE;
					end
				end
				ST_EXEC: begin
					unique case (mode_q)
						ttcs_pkg::MODE_PUT: begin
							if (need_scroll) begin
								col_q <= '0;
								row_q <= ROW_MAX;
								cnt_q <= '0;
								wv_s1 <= 1'b0;
								st_q  <= ST_SCROLL;
							end else begin
								col_q <= nl ? p_col : p_col + ttcs_pkg::COL_W'(1);
								row_q <= p_row;
								st_q  <= ST_FIN;
							end
						end
						ttcs_pkg::MODE_SET: begin
							col_q <= (ncol_q > COL_MAX) ? COL_MAX : ncol_q;
							row_q <= (nrow_q > ROW_MAX) ? ROW_MAX : nrow_q;
							st_q  <= ST_FIN;
						end
						ttcs_pkg::MODE_CLEAR: begin
							cnt_q <= '0;
							st_q  <= ST_FILL;
						end
						default: begin
							st_q <= ST_FIN;
						end
					endcase
				end
				ST_SCROLL: begin
					if (cnt_q < COPY_END) begin
						wv_s1 <= 1'b1;
						wa_s1 <= cnt_q[AW-1:0];
						cnt_q <= cnt_q + CW'(1);
					end else begin
						wv_s1 <= 1'b0;
						cnt_q <= BOTTOM_ROW;
						st_q  <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (cnt_q == FILL_END - CW'(1)) begin
						init_q <= 1'b0;
						if (init_q) begin
							st_q <= ST_IDLE;
						end else if (mode_q == ttcs_pkg::MODE_CLEAR) begin
							st_q <= ST_FIN;
						end else begin
							st_q <= ST_POST;
						end
					end
					cnt_q <= cnt_q + CW'(1);
				end
				ST_POST: begin
					if (!nl) begin
						col_q <= col_q + ttcs_pkg::COL_W'(1);
					end
					st_q <= ST_FIN;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= item.mode;
			char_q <= item.char_code;
			ncol_q <= item.new_col;
			nrow_q <= item.new_row;
			cidx_q <= item.cell_index;
		end
		if (st_q == ST_EXEC) begin
			rd_ok_q <= rd_in_range;
		end
		if (load_out) begin
			out_col_q  <= col_q;
			out_row_q  <= row_q;
			out_cell_q <= (mode_q == ttcs_pkg::MODE_READ && rd_ok_q) ? ram_rdata : '0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.cursor_col = out_col_q;
	assign result.cursor_row = out_row_q;
	assign result.cell_value = out_cell_q;

	`TTCS_ASSERT(a_col_bound, col_q <= COL_MAX)
	`TTCS_ASSERT(a_row_bound, row_q <= ROW_MAX)
	`TTCS_ASSERT(a_busy_no_ready, (st_q == ST_SCROLL || st_q == ST_FILL) |-> !item.ready)
	`TTCS_ASSERT_ALWAYS(a_init_fill, init_q |-> (st_q == ST_FILL))
endmodule

FILE: sim/text_terminal_cursor_scroll_test.sv
// Self-checking testbench for the text terminal: cursor, lazy wrap, scroll, clear and cell read.
module text_terminal_cursor_scroll_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ttcs_pkg::*;

	localparam int SETTLE_CYCLES = CELL_COUNT + SCREEN_WIDTH + 16;
	localparam longint CYCLE_LIMIT = 20_000_000;

	typedef struct packed {
		logic [1:0]        mode;
		logic [CHAR_W-1:0] char_code;
		logic [COL_W-1:0]  new_col;
		logic [ROW_W-1:0]  new_row;
		logic [IDX_W-1:0]  cell_index;
	} command_t;

	typedef struct packed {
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic [CELL_W-1:0] cell_value;
	} cursor_report_t;

	logic clk;
	logic arst_n;

	ttcs_item_if   item_ch();
	ttcs_result_if result_ch();
	ttcs_cfg_if    cfg_ch();

	text_terminal_cursor_scroll u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// screen image and cursor as the block should hold them
	logic [CELL_W-1:0] screen_img [CELL_COUNT];
	int                cur_col;
	int                cur_row;
	logic [CHAR_W-1:0] text_attr;

	cursor_report_t pending_reports [$];

	int     send_idle_pct;
	int     recv_stall_pct;
	int     err_count;
	int     cmd_count;
	int     result_count;
	int     scroll_count;
	int     clear_count;
	int     read_count;
	int     color_writes;
	longint cycle_count;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_reports.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
			result_count);
		err_count++;
	endtask

	always @(posedge clk) begin : check_results
		cursor_report_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			result_count++;
			if (pending_reports.size() == 0) begin
				report_mismatch("unexpected transaction, cursor_col", result_ch.cursor_col, -1);
			end else begin
				want = pending_reports.pop_front();
				if (result_ch.cursor_col !== want.cursor_col)
					report_mismatch("cursor_col", result_ch.cursor_col, want.cursor_col);
				if (result_ch.cursor_row !== want.cursor_row)
					report_mismatch("cursor_row", result_ch.cursor_row, want.cursor_row);
				if (result_ch.cell_value !== want.cell_value)
					report_mismatch("cell_value", result_ch.cell_value, want.cell_value);
			end
		end
	end

	function automatic logic [CELL_W-1:0] blank_cell();
		return {text_attr, BLANK_CODE};
	endfunction

	function automatic void scroll_screen();
		for (int i = 0; i < CELL_COUNT - SCREEN_WIDTH; i++)
			screen_img[i] = screen_img[i + SCREEN_WIDTH];
		for (int i = CELL_COUNT - SCREEN_WIDTH; i < CELL_COUNT; i++)
			screen_img[i] = blank_cell();
		scroll_count++;
	endfunction

	function automatic cursor_report_t apply_command(input command_t cmd);
		cursor_report_t rpt;
		int             addr;
		logic           is_newline;
		rpt.cell_value = '0;
		case (cmd.mode)
			MODE_PUT: begin
				is_newline = (cmd.char_code == NEWLINE_CODE);
				if (cur_col >= SCREEN_WIDTH || is_newline) begin
					cur_col = 0;
					if (cur_row >= SCREEN_HEIGHT - 1) begin
						cur_row = SCREEN_HEIGHT - 1;
						scroll_screen();
					end else begin
						cur_row++;
					end
				end
				if (!is_newline) begin
					addr = cur_row * SCREEN_WIDTH + cur_col;
					screen_img[addr] = {text_attr, cmd.char_code};
					cur_col++;
				end
			end
			MODE_SET: begin
				cur_col = (cmd.new_col > SCREEN_WIDTH) ? SCREEN_WIDTH : int'(cmd.new_col);
				cur_row = (cmd.new_row > SCREEN_HEIGHT - 1) ? SCREEN_HEIGHT - 1
					: int'(cmd.new_row);
			end
			MODE_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++)
					screen_img[i] = blank_cell();
				clear_count++;
			end
			default: begin
				read_count++;
				if (cmd.cell_index < CELL_COUNT)
					rpt.cell_value = screen_img[cmd.cell_index];
			end
		endcase
		rpt.cursor_col = COL_W'(cur_col);
		rpt.cursor_row = ROW_W'(cur_row);
		return rpt;
	endfunction

	task automatic send_command(input command_t cmd);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
		end
		@(negedge clk);
		item_ch.valid      <= 1'b1;
		item_ch.mode       <= cmd.mode;
		item_ch.char_code  <= cmd.char_code;
		item_ch.new_col    <= cmd.new_col;
		item_ch.new_row    <= cmd.new_row;
		item_ch.cell_index <= cmd.cell_index;
		do @(posedge clk); while (!item_ch.ready);
		pending_reports.push_back(apply_command(cmd));
		cmd_count++;
	endtask

	task automatic send_fields(input logic [1:0] mode, input int char_code, input int col,
		input int row, input int idx);
		command_t cmd;
		cmd.mode       = mode;
		cmd.char_code  = CHAR_W'(char_code);
		cmd.new_col    = COL_W'(col);
		cmd.new_row    = ROW_W'(row);
		cmd.cell_index = IDX_W'(idx);
		send_command(cmd);
	endtask

	// mostly put traffic with random char codes, cursor moves biased to the bottom rows so scrolls occur
	function automatic command_t random_command();
		command_t cmd;
		int       pick;
		pick           = $urandom_range(99);
		cmd.char_code  = CHAR_W'($urandom_range(255));
		cmd.new_col    = COL_W'($urandom_range(127));
		cmd.new_row    = ROW_W'($urandom_range(31));
		cmd.cell_index = IDX_W'($urandom_range(2047));
		if (pick < 60) begin
			cmd.mode = MODE_PUT;
		end else if (pick < 63) begin
			cmd.mode      = MODE_PUT;
			cmd.char_code = NEWLINE_CODE;
		end else if (pick < 73) begin
			cmd.mode = MODE_SET;
			case ($urandom_range(3))
				1: begin
					cmd.new_col = COL_W'($urandom_range(SCREEN_WIDTH));
					cmd.new_row = ROW_W'($urandom_range(SCREEN_HEIGHT - 1));
				end
				2: begin
					cmd.new_col = COL_W'($urandom_range(SCREEN_WIDTH, SCREEN_WIDTH - 3));
					cmd.new_row = ROW_W'(SCREEN_HEIGHT - 1);
				end
				3: begin
					cmd.new_col = COL_W'($urandom_range(SCREEN_WIDTH));
					cmd.new_row = ROW_W'($urandom_range(SCREEN_HEIGHT - 1, SCREEN_HEIGHT - 3));
				end
				default: ;
			endcase
		end else if (pick < 75) begin
			cmd.mode = MODE_CLEAR;
		end else begin
			cmd.mode = MODE_READ;
			case ($urandom_range(3))
				1, 2: cmd.cell_index = IDX_W'((cur_row > SCREEN_HEIGHT - 1 ? SCREEN_HEIGHT - 1
					: cur_row) * SCREEN_WIDTH + $urandom_range(SCREEN_WIDTH - 1));
				3: cmd.cell_index = IDX_W'($urandom_range(CELL_COUNT - 1));
				default: ;
			endcase
		end
		return cmd;
	endfunction

	task automatic send_random(input int count);
		repeat (count) send_command(random_command());
	endtask

	task automatic drain_results();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_text_color(input logic [CHAR_W-1:0] value);
		drain_results();
		@(negedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.text_color <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		text_attr = value;
		color_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_directed();
		send_fields(MODE_READ, 255, 127, 31, 0);
		send_fields(MODE_READ, 0, 0, 0, CELL_COUNT - 1);
		send_fields(MODE_READ, 0, 0, 0, CELL_COUNT);
		send_fields(MODE_READ, 255, 127, 31, 2047);
		send_fields(MODE_PUT, 65, 127, 31, 2047);
		send_fields(MODE_PUT, 0, 0, 0, 0);
		send_fields(MODE_PUT, 255, 0, 0, 0);
		send_fields(MODE_PUT, NEWLINE_CODE, 127, 31, 2047);
		send_fields(MODE_READ, 0, 0, 0, 2);
		send_fields(MODE_SET, 0, 127, 31, 2047);
		send_fields(MODE_PUT, 8'h55, 0, 0, 0);
		send_fields(MODE_SET, 255, SCREEN_WIDTH, 3, 0);
		send_fields(MODE_PUT, 8'hAA, 0, 0, 0);
		send_fields(MODE_SET, 0, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0);
		send_fields(MODE_PUT, 90, 0, 0, 0);
		send_fields(MODE_PUT, NEWLINE_CODE, 0, 0, 0);
		send_fields(MODE_READ, 0, 0, 0, (SCREEN_HEIGHT - 1) * SCREEN_WIDTH - 1);
		send_fields(MODE_READ, 0, 0, 0, 4 * SCREEN_WIDTH - SCREEN_WIDTH);
		send_fields(MODE_CLEAR, 255, 127, 31, 2047);
		send_fields(MODE_READ, 0, 0, 0, (SCREEN_HEIGHT - 1) * SCREEN_WIDTH - 1);
		send_fields(MODE_SET, 255, 0, 0, 2047);
		send_fields(MODE_PUT, 33, 0, 0, 0);
		send_fields(MODE_READ, 0, 0, 0, 0);
	endtask

	task automatic test_color_settings();
		logic [CHAR_W-1:0] colors [3];
		colors = '{8'h00, 8'hFF, 8'h5A};
		foreach (colors[i]) begin
			write_text_color(colors[i]);
			send_random(20);
			send_fields(MODE_PUT, NEWLINE_CODE, 0, 0, 0);
			send_fields(MODE_PUT, 8'h7E, 0, 0, 0);
			send_fields(MODE_CLEAR, 0, 0, 0, 0);
			send_fields(MODE_READ, 0, 0, 0, $urandom_range(CELL_COUNT - 1));
			send_random(10);
		end
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input int count);
		write_text_color(CHAR_W'($urandom_range(255)));
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		send_random(count);
	endtask

	initial begin
		arst_n             = 1'b0;
		item_ch.valid      = 1'b0;
		item_ch.mode       = MODE_PUT;
		item_ch.char_code  = '0;
		item_ch.new_col    = '0;
		item_ch.new_row    = '0;
		item_ch.cell_index = '0;
		result_ch.ready    = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.text_color  = '0;
		send_idle_pct      = 32;
		recv_stall_pct     = 51;
		err_count          = 0;
		cmd_count          = 0;
		result_count       = 0;
		scroll_count       = 0;
		clear_count        = 0;
		read_count         = 0;
		color_writes       = 0;
		cycle_count        = 0;
		cur_col            = 0;
		cur_row            = 0;
		text_attr          = RESET_ATTR;
		for (int i = 0; i < CELL_COUNT; i++)
			screen_img[i] = blank_cell();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_color_settings();
		test_random_traffic(32, 51, 560);
		test_random_traffic(51, 32, 560);
		test_random_traffic(0, 0, 560);

		drain_results();
		$display("%0d commands, %0d transactions checked: %0d scrolls, %0d clears, %0d reads",
			cmd_count, result_count, scroll_count, clear_count, read_count);
		$display("%0d text color writes, %0d mismatches", color_writes, err_count);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/ttcs_pkg.sv
rtl/ttcs_item_if.sv
rtl/ttcs_result_if.sv
rtl/ttcs_cfg_if.sv
rtl/ttcs_ram.sv
rtl/text_terminal_cursor_scroll.sv
sim/text_terminal_cursor_scroll_test.sv
